### rtl/core/pssa_pkg.sv
// ----------------------------------------------------------------------------
// pssa_pkg
// Shared types and constants of the page span split allocator: field widths,
// result status codes, register indexes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pssa_pkg;

   // Field widths of the request, result and register channels
   localparam int PAGES_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int START_W    = 32;
   localparam int GRANT_W    = 7;
   localparam int CFG_W      = 32;
   localparam int CSR_ADDR_W = 4;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_POOL_BASE  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_POOL_LIMIT = CSR_ADDR_W'(1);

   localparam logic [CFG_W-1:0] POOL_BASE_RESET  = CFG_W'(0);
   localparam logic [CFG_W-1:0] POOL_LIMIT_RESET = CFG_W'(65536);

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_OOM      = 2'd2,
      ST_DROPPED  = 2'd3
   } alloc_status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_PICK,
      S_POP,
      S_LOAD,
      S_PUSH,
      S_DONE
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;    // capture request size, clear result
      logic search;      // register first stage of free list search
      logic set_bad;     // result is bad size
      logic set_oom;     // result is out of memory
      logic take;        // take found list, read its fill count
      logic carve;       // carve a fresh block from the pool
      logic pop;         // drop fill count, read run store
      logic load_start;  // capture popped start page
      logic push;        // push remainder if its list has room
      logic rsp_load;    // load output register
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic bad_size;
      logic found;
      logic pool_short;
      logic rem_fresh;
      logic rem_taken;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/pssa_intf.sv
// ----------------------------------------------------------------------------
// pssa_intf
// Valid/ready channel interfaces of the allocator: request, result and
// register write.
// ----------------------------------------------------------------------------
interface pssa_req_if;
   import pssa_pkg::*;

   logic               valid;
   logic               ready;
   logic [PAGES_W-1:0] pages_wanted;

   modport source (output valid, output pages_wanted, input ready);
   modport sink   (input valid, input pages_wanted, output ready);
endinterface

interface pssa_rsp_if;
   import pssa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [START_W-1:0]  start_page;
   logic [GRANT_W-1:0]  granted_pages;

   modport source (output valid, output status, output start_page,
                   output granted_pages, input ready);
   modport sink   (input valid, input status, input start_page,
                   input granted_pages, output ready);
endinterface

interface pssa_csr_if;
   import pssa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CFG_W-1:0]      wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

### rtl/core/pssa_ram.sv
// ----------------------------------------------------------------------------
// pssa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pssa_ctrl.sv
// ----------------------------------------------------------------------------
// pssa_ctrl
// Allocation sequencer: walks one request through size check, free list
// search, pop, remainder push and result hand-off.
// ----------------------------------------------------------------------------
module pssa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pssa_pkg::dp_status_type stat,
   output pssa_pkg::dp_cmd_type    cmd
);
   import pssa_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = stat.bad_size ? S_DONE : S_PICK;
         end
         S_PICK: begin
            if (stat.found) begin
               state_in = S_POP;
            end else if (stat.pool_short) begin
               state_in = S_DONE;
            end else begin
               state_in = stat.rem_fresh ? S_PUSH : S_DONE;
            end
         end
         S_POP: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = stat.rem_taken ? S_PUSH : S_DONE;
         end
         S_PUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_SEARCH: begin
            cmd.search  = 1'b1;
            cmd.set_bad = stat.bad_size;
         end
         S_PICK: begin
            if (stat.found) begin
               cmd.take = 1'b1;
            end else if (stat.pool_short) begin
               cmd.set_oom = 1'b1;
            end else begin
               cmd.carve = 1'b1;
            end
         end
         S_POP: begin
            cmd.pop = 1'b1;
         end
         S_LOAD: begin
            cmd.load_start = 1'b1;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
         end
         S_DONE: begin
            cmd.rsp_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/core/pssa_dpath.sv
// ----------------------------------------------------------------------------
// pssa_dpath
// Allocator datapath: pool registers, nonempty mask with two-stage search,
// fill count RAM, run store RAM, split arithmetic and output register.
// ----------------------------------------------------------------------------
module pssa_dpath #(
   parameter int SIZE_CLASSES     = 128,
   parameter int LIST_DEPTH       = 16,
   parameter int PAGE_NUMBER_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pssa_pkg::dp_cmd_type              cmd,
   output pssa_pkg::dp_status_type           stat,
   input  logic [pssa_pkg::PAGES_W-1:0]      req_pages_wanted,
   input  logic                              csr_we,
   input  logic [pssa_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pssa_pkg::CFG_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pssa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pssa_pkg::START_W-1:0]      rsp_start_page,
   output logic [pssa_pkg::GRANT_W-1:0]      rsp_granted_pages
);
   import pssa_pkg::*;

   localparam int CLS_W       = $clog2(SIZE_CLASSES);
   localparam int FILL_W      = $clog2(LIST_DEPTH + 1);
   localparam int STORE_DEPTH = SIZE_CLASSES * LIST_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int GRP         = 16;
   localparam int GRP_W       = $clog2(GRP);
   localparam int NGRP        = (SIZE_CLASSES + GRP - 1) / GRP;
   localparam int GSEL_W      = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PAD         = NGRP * GRP;
   localparam int SUM_W       = (PAGE_NUMBER_BITS > 33) ? PAGE_NUMBER_BITS : 33;
   localparam int KCMP_W      = PAGES_W + 1;

   localparam logic [CLS_W-1:0]       BIG_RUN   = CLS_W'(SIZE_CLASSES - 1);
   localparam logic [CFG_W-1:0]       BIG_PAGES = CFG_W'(SIZE_CLASSES - 1);
   localparam logic [ADDR_W-1:0]      LD_A      = ADDR_W'(LIST_DEPTH);
   localparam logic [FILL_W-1:0]      LD_F      = FILL_W'(LIST_DEPTH);

   // Registers
   logic [PAGES_W-1:0]          k_ff, k_in;
   logic [SIZE_CLASSES-1:0]     mask_ff, mask_in;
   logic [NGRP-1:0]             grp_any_ff, grp_any_in;
   logic [GRP_W-1:0]            grp_first_ff [NGRP];
   logic [GRP_W-1:0]            grp_first_in [NGRP];
   logic [CLS_W-1:0]            run_ff, run_in;
   logic [CLS_W-1:0]            rem_ff, rem_in;
   logic [PAGE_NUMBER_BITS-1:0] start_ff, start_in;
   logic [CFG_W-1:0]            used_ff, used_in;
   logic [CFG_W-1:0]            base_ff, base_in;
   logic [CFG_W-1:0]            limit_ff, limit_in;
   alloc_status_type            st_ff, st_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]          rsp_start_ff, rsp_start_in;
   logic [GRANT_W-1:0]          rsp_granted_ff, rsp_granted_in;

   // Combinational
   logic [PAD-1:0]              elig;
   logic [GSEL_W-1:0]           pick_grp;
   logic [CLS_W-1:0]            pick_cls;
   logic [CLS_W-1:0]            k_cls;
   logic [CLS_W-1:0]            rem_cls;
   logic [FILL_W-1:0]           pop_fill;
   logic [FILL_W-1:0]           rem_fill;
   logic                        rem_room;
   logic [SUM_W-1:0]            carve_sum;
   logic [SUM_W-1:0]            start_ext;

   // RAM ports
   logic                        fill_we;
   logic [CLS_W-1:0]            fill_waddr;
   logic [FILL_W-1:0]           fill_wdata;
   logic                        fill_re;
   logic [CLS_W-1:0]            fill_raddr;
   logic [FILL_W-1:0]           fill_rdata;
   logic                        store_we;
   logic [ADDR_W-1:0]           store_waddr;
   logic [PAGE_NUMBER_BITS-1:0] store_wdata;
   logic                        store_re;
   logic [ADDR_W-1:0]           store_raddr;
   logic [PAGE_NUMBER_BITS-1:0] store_rdata;

   // First search stage: lists at or above the request size, per group
   always_comb begin
      elig = '0;
      for (int i = 0; i < SIZE_CLASSES; i++) begin
         elig[i] = mask_ff[i] && (KCMP_W'(k_ff) <= KCMP_W'(i));
      end
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g]   = |elig[g*GRP +: GRP];
         grp_first_in[g] = '0;
         for (int b = GRP - 1; b >= 0; b--) begin
            if (elig[g*GRP + b]) begin
               grp_first_in[g] = GRP_W'(b);
            end
         end
      end
   end

   // Second search stage: lowest group with a hit
   always_comb begin
      pick_grp = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick_grp = GSEL_W'(g);
         end
      end
      pick_cls = CLS_W'({pick_grp, grp_first_ff[pick_grp]});
   end

   // Split arithmetic and list bookkeeping
   always_comb begin
      k_cls     = CLS_W'(k_ff);
      rem_cls   = (cmd.carve ? BIG_RUN : run_ff) - k_cls;
      pop_fill  = fill_rdata - FILL_W'(1);
      rem_fill  = mask_ff[rem_ff] ? fill_rdata : '0;
      rem_room  = rem_fill < LD_F;
      carve_sum = SUM_W'(base_ff) + SUM_W'(used_ff);
      start_ext = SUM_W'(start_ff);
   end

   // Status to controller
   always_comb begin
      stat.bad_size   = (k_ff == '0) || (KCMP_W'(k_ff) >= KCMP_W'(SIZE_CLASSES));
      stat.found      = |grp_any_ff;
      stat.pool_short = ({1'b0, used_ff} + {1'b0, BIG_PAGES}) > {1'b0, limit_ff};
      stat.rem_fresh  = BIG_RUN > k_cls;
      stat.rem_taken  = run_ff > k_cls;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // RAM port control
   always_comb begin
      fill_re     = cmd.take || cmd.carve || cmd.load_start;
      fill_raddr  = cmd.take ? pick_cls : rem_cls;
      fill_we     = cmd.pop || (cmd.push && rem_room);
      fill_waddr  = cmd.pop ? run_ff : rem_ff;
      fill_wdata  = cmd.pop ? pop_fill : rem_fill + FILL_W'(1);
      store_re    = cmd.pop;
      store_raddr = ADDR_W'(run_ff) * LD_A + ADDR_W'(pop_fill);
      store_we    = cmd.push && rem_room;
      store_waddr = ADDR_W'(rem_ff) * LD_A + ADDR_W'(rem_fill);
      store_wdata = start_ff + PAGE_NUMBER_BITS'(k_ff);
   end

   // Next register values
   always_comb begin
      k_in           = k_ff;
      mask_in        = mask_ff;
      run_in         = run_ff;
      rem_in         = rem_ff;
      start_in       = start_ff;
      used_in        = used_ff;
      base_in        = base_ff;
      limit_in       = limit_ff;
      st_in          = st_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_granted_in = rsp_granted_ff;

      // Register writes
      if (csr_we && (csr_addr == CSR_POOL_BASE)) begin
         base_in = csr_wdata;
      end
      if (csr_we && (csr_addr == CSR_POOL_LIMIT)) begin
         limit_in = csr_wdata;
      end

      // Request capture
      if (cmd.load_req) begin
         k_in     = req_pages_wanted;
         st_in    = ST_OK;
         start_in = '0;
      end
      if (cmd.set_bad) begin
         st_in = ST_BAD_SIZE;
      end
      if (cmd.set_oom) begin
         st_in = ST_OOM;
      end

      // Take a listed run
      if (cmd.take) begin
         run_in = pick_cls;
      end
      if (cmd.pop && (pop_fill == '0)) begin
         mask_in[run_ff] = 1'b0;
      end
      if (cmd.load_start) begin
         start_in = store_rdata;
         rem_in   = rem_cls;
      end

      // Carve a fresh block
      if (cmd.carve) begin
         start_in = carve_sum[PAGE_NUMBER_BITS-1:0];
         used_in  = used_ff + BIG_PAGES;
         run_in   = BIG_RUN;
         rem_in   = rem_cls;
      end

      // Push the remainder or flag the drop
      if (cmd.push) begin
         if (rem_room) begin
            mask_in[rem_ff] = 1'b1;
         end else begin
            st_in = ST_DROPPED;
         end
      end

      // Output register
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = st_ff;
         rsp_start_in   = start_ext[START_W-1:0];
         rsp_granted_in = ((st_ff == ST_BAD_SIZE) || (st_ff == ST_OOM)) ?
                          '0 : k_ff[GRANT_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         used_ff      <= '0;
         base_ff      <= POOL_BASE_RESET;
         limit_ff     <= POOL_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         used_ff      <= used_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      run_ff         <= run_in;
      rem_ff         <= rem_in;
      start_ff       <= start_in;
      st_ff          <= st_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_granted_ff <= rsp_granted_in;
      if (cmd.search) begin
         grp_any_ff   <= grp_any_in;
         grp_first_ff <= grp_first_in;
      end
   end

   // Fill count per list; an entry reads as zero while its mask bit is clear
   pssa_ram #(
      .WIDTH (FILL_W),
      .DEPTH (SIZE_CLASSES)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_en   (fill_re),
      .rd_addr (fill_raddr),
      .rd_data (fill_rdata)
   );

   // Start pages of free runs, LIST_DEPTH slots per list
   pssa_ram #(
      .WIDTH (PAGE_NUMBER_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_en   (store_re),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_start_page    = rsp_start_ff;
   assign rsp_granted_pages = rsp_granted_ff;

endmodule

### rtl/core/page_span_split_allocator.sv
// ----------------------------------------------------------------------------
// page_span_split_allocator
// Segregated free list page allocator with run splitting and a bump pool.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A bad size ends at the search state and
// an exhausted pool at the pick state; a fresh block carved from the pool, or
// a run popped from a free list with its start page loaded, is followed by a
// remainder push when one is left. The path runs through the two-stage search
// over the nonempty mask and the registered reads of the fill count RAM and
// the run store RAM, which are used in turn. A new request is taken while the
// previous result still waits in the output register. The run store needs no
// clearing pass after reset: only slots below a list's fill count are read,
// and a list's fill count reads as zero until its nonempty bit is set.
// Registers are written at any time through the csr channel, which is always
// ready; change them only while no request is in flight.
// ----------------------------------------------------------------------------
module page_span_split_allocator #(
   parameter int SIZE_CLASSES     = 128,
   parameter int LIST_DEPTH       = 16,
   parameter int PAGE_NUMBER_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   pssa_req_if.sink   req_bus,
   pssa_rsp_if.source rsp_bus,
   pssa_csr_if.sink   csr_bus
);
   import pssa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;
   logic          csr_we;

   // Register channel never stalls
   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid && csr_bus.ready;

   pssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pssa_dpath #(
      .SIZE_CLASSES     (SIZE_CLASSES),
      .LIST_DEPTH       (LIST_DEPTH),
      .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_pages_wanted  (req_bus.pages_wanted),
      .csr_we            (csr_we),
      .csr_addr          (csr_bus.addr),
      .csr_wdata         (csr_bus.wdata),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_start_page    (rsp_bus.start_page),
      .rsp_granted_pages (rsp_bus.granted_pages)
   );

endmodule

### rtl/core/pssa_checker.sv
// ----------------------------------------------------------------------------
// pssa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pssa_checker (
   input logic        clock,
   input logic        reset,
   pssa_req_if.sink   req_bus,
   pssa_rsp_if.source rsp_bus
);
   import pssa_pkg::*;

   // One request in flight: ready drops after a transaction
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while another is in flight");

   // A result never appears in the cycle after its request
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !$rose(rsp_bus.valid))
      else $error("result too early after request");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=>
         (rsp_bus.valid && $stable(rsp_bus.status) && $stable(rsp_bus.start_page)))
      else $error("stalled result changed");

   // Errors carry no grant
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && ((rsp_bus.status == ST_BAD_SIZE) ||
                         (rsp_bus.status == ST_OOM))) |->
         ((rsp_bus.start_page == '0) && (rsp_bus.granted_pages == '0)))
      else $error("error result carries a grant");

endmodule

bind page_span_split_allocator pssa_checker u_pssa_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

### bench/page_span_split_allocator_test.sv
// ----------------------------------------------------------------------------
// page_span_split_allocator_test
// Self-checking bench for the page span split allocator. A planned stream of
// allocation requests, drain points and pool register writes feeds a clocked
// driver; a scoreboard model of the free lists and the bump pool predicts
// every grant, and a clocked monitor compares each result transaction field
// by field. Sender bursts, receiver stall patterns and several pool settings
// (base and limit at both extremes, a nearly exhausted pool) are exercised.
// ----------------------------------------------------------------------------
module page_span_split_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pssa_pkg::*;

   localparam int SIZE_CLASSES     = 128;
   localparam int LIST_DEPTH       = 16;
   localparam int PAGE_NUMBER_BITS = 32;
   localparam int BIG_RUN          = SIZE_CLASSES - 1;
   localparam int SETTLE_CYCLES    = 10;
   localparam int TAIL_CYCLES      = 12;
   localparam int IDLE_LIMIT       = 4000;

   typedef enum logic [1:0] {
      PLAN_ALLOC,
      PLAN_SETTLE,
      PLAN_WRITE
   } plan_kind_type;

   typedef struct {
      plan_kind_type         kind;
      logic [PAGES_W-1:0]    pages;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CFG_W-1:0]      value;
      bit                    above_used;  // value is added to pages used so far
   } plan_step_type;

   typedef struct {
      alloc_status_type    status;
      logic [START_W-1:0]  start_page;
      logic [GRANT_W-1:0]  granted_pages;
   } grant_type;

   logic clock = 1'b0;
   logic reset;

   pssa_req_if req_if ();
   pssa_rsp_if rsp_if ();
   pssa_csr_if csr_if ();

   page_span_split_allocator #(
      .SIZE_CLASSES     (SIZE_CLASSES),
      .LIST_DEPTH       (LIST_DEPTH),
      .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Allocator shadow state
   logic [START_W-1:0] run_store [SIZE_CLASSES][LIST_DEPTH];
   int unsigned        list_fill [SIZE_CLASSES];
   logic [CFG_W-1:0]   pool_used;
   logic [CFG_W-1:0]   base_page;
   logic [CFG_W-1:0]   limit_pages;

   plan_step_type request_plan [$];
   grant_type     expected_grants [$];

   // Driver bookkeeping
   bit                    req_busy;
   bit                    csr_busy;
   logic [PAGES_W-1:0]    req_pages;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CFG_W-1:0]      csr_value;
   int unsigned           burst_left;
   int unsigned           gap_left;
   int unsigned           settle_count;
   plan_step_type         step;

   // Receiver stall pattern
   logic [15:0] stall_pattern;
   int unsigned pattern_age;

   // Tallies
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned writes_done;
   int unsigned drains_done;
   int unsigned ok_count;
   int unsigned dropped_count;
   int unsigned bad_count;
   int unsigned oom_count;

   // Clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Return the allocator shadow to its power-on state
   function automatic void clear_allocator();
      foreach (list_fill[i]) list_fill[i] = 0;
      pool_used   = '0;
      base_page   = POOL_BASE_RESET;
      limit_pages = POOL_LIMIT_RESET;
   endfunction

   function automatic void write_pool_reg(input logic [CSR_ADDR_W-1:0] addr,
                                          input logic [CFG_W-1:0] value);
      if (addr == CSR_POOL_BASE)
         base_page = value;
      else if (addr == CSR_POOL_LIMIT)
         limit_pages = value;
   endfunction

   // Predict the grant for one accepted request and update the shadow lists
   function automatic void predict_grant(input logic [PAGES_W-1:0] wanted);
      grant_type          g;
      int unsigned        cls;
      int unsigned        run_len;
      int unsigned        rem;
      logic [START_W-1:0] start;
      bit                 found;
      g.status        = ST_OK;
      g.start_page    = '0;
      g.granted_pages = '0;
      found   = 1'b0;
      run_len = 0;
      start   = '0;
      if (wanted == 0 || wanted >= SIZE_CLASSES) begin
         g.status = ST_BAD_SIZE;
      end else begin
         // take the first nonempty list at or above the size
         for (cls = wanted; cls < SIZE_CLASSES && !found; cls++) begin
            if (list_fill[cls] != 0) begin
               list_fill[cls]--;
               start   = run_store[cls][list_fill[cls]];
               run_len = cls;
               found   = 1'b1;
            end
         end
         // fall back to a fresh block from the pool
         if (!found) begin
            if ({1'b0, pool_used} + 33'(BIG_RUN) > {1'b0, limit_pages}) begin
               g.status = ST_OOM;
            end else begin
               start     = base_page + pool_used;
               pool_used = pool_used + CFG_W'(BIG_RUN);
               run_len   = BIG_RUN;
               found     = 1'b1;
            end
         end
         if (found) begin
            // split off the tail, drop it when its list is full
            if (run_len > wanted) begin
               rem = run_len - wanted;
               if (list_fill[rem] >= LIST_DEPTH) begin
                  g.status = ST_DROPPED;
               end else begin
                  run_store[rem][list_fill[rem]] = start + START_W'(wanted);
                  list_fill[rem]++;
               end
            end
            g.start_page    = start;
            g.granted_pages = wanted[GRANT_W-1:0];
         end
      end
      expected_grants.push_back(g);
   endfunction

   // Plan building
   function automatic void plan_alloc(input logic [PAGES_W-1:0] pages);
      plan_step_type s;
      s.kind       = PLAN_ALLOC;
      s.pages      = pages;
      s.addr       = '0;
      s.value      = '0;
      s.above_used = 1'b0;
      request_plan.push_back(s);
   endfunction

   function automatic void plan_settle();
      plan_step_type s;
      s.kind       = PLAN_SETTLE;
      s.pages      = '0;
      s.addr       = '0;
      s.value      = '0;
      s.above_used = 1'b0;
      request_plan.push_back(s);
   endfunction

   function automatic void plan_write(input logic [CSR_ADDR_W-1:0] addr,
                                      input logic [CFG_W-1:0] value,
                                      input bit above_used);
      plan_step_type s;
      s.kind       = PLAN_WRITE;
      s.pages      = '0;
      s.addr       = addr;
      s.value      = value;
      s.above_used = above_used;
      request_plan.push_back(s);
   endfunction

   // Mostly valid sizes weighted toward small and large runs
   function automatic logic [PAGES_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return '0;
      else if (r < 7)
         return PAGES_W'($urandom_range(SIZE_CLASSES, 255));
      else if (r < 42)
         return PAGES_W'($urandom_range(1, 24));
      else if (r < 72)
         return PAGES_W'($urandom_range(64, SIZE_CLASSES - 1));
      else
         return PAGES_W'($urandom_range(1, SIZE_CLASSES - 1));
   endfunction

   // Random requests, with runs of one large size to fill remainder lists
   function automatic void plan_random(input int unsigned count);
      int unsigned         added;
      int unsigned         repeats;
      logic [PAGES_W-1:0]  pages;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 9) == 0) begin
            pages   = PAGES_W'($urandom_range(70, SIZE_CLASSES - 1));
            repeats = $urandom_range(3, 18);
            for (int unsigned i = 0; i < repeats && added < count; i++) begin
               plan_alloc(pages);
               added++;
            end
         end else begin
            plan_alloc(pick_size());
            added++;
         end
      end
   endfunction

   // Driver: issue planned requests, drain points and register writes
   always @(posedge clock) begin
      if (reset) begin
         clear_allocator();
         req_busy     = 1'b0;
         csr_busy     = 1'b0;
         req_pages    = '0;
         csr_addr     = '0;
         csr_value    = '0;
         burst_left   = $urandom_range(1, 32);
         gap_left     = 0;
         settle_count = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_grant(req_if.pages_wanted);
            req_busy = 1'b0;
         end
         if (csr_if.valid && csr_if.ready) begin
            write_pool_reg(csr_if.addr, csr_if.wdata);
            writes_done++;
            csr_busy = 1'b0;
         end
         if (!req_busy && !csr_busy && request_plan.size() != 0) begin
            case (request_plan[0].kind)
               PLAN_ALLOC: begin
                  if (gap_left != 0) begin
                     gap_left--;
                  end else begin
                     step      = request_plan.pop_front();
                     req_busy  = 1'b1;
                     req_pages = step.pages;
                     // end of burst: choose the next gap and burst length
                     if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                     end else begin
                        burst_left--;
                     end
                  end
               end
               PLAN_SETTLE: begin
                  // hold until every grant is back and the block has gone idle
                  if (expected_grants.size() != 0) begin
                     settle_count = 0;
                  end else if (settle_count >= SETTLE_CYCLES) begin
                     step         = request_plan.pop_front();
                     settle_count = 0;
                     drains_done++;
                  end else begin
                     settle_count++;
                  end
               end
               PLAN_WRITE: begin
                  step      = request_plan.pop_front();
                  csr_busy  = 1'b1;
                  csr_addr  = step.addr;
                  csr_value = step.above_used ? pool_used + step.value : step.value;
               end
               default: begin
                  step = request_plan.pop_front();
               end
            endcase
         end
      end
      req_if.valid        <= req_busy;
      req_if.pages_wanted <= req_pages;
      csr_if.valid        <= csr_busy;
      csr_if.addr         <= csr_addr;
      csr_if.wdata        <= csr_value;
   end

   // Receiver: rotate a stall pattern and reload it when its random age runs out
   always @(posedge clock) begin
      if (reset) begin
         stall_pattern = 16'hFFFF;
         pattern_age   = 0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern = 16'hFFFF;
               1:       stall_pattern = 16'($urandom) | 16'h0001;
               2:       stall_pattern = 16'h8001;
               default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
            endcase
            pattern_age = $urandom_range(64, 300);
         end else begin
            pattern_age--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         end
      end
      rsp_if.ready <= stall_pattern[0];
   end

   // Monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d start %0h pages %0d",
                     $time, rsp_if.status, rsp_if.start_page, rsp_if.granted_pages);
            error_count++;
         end else begin
            grant_type g;
            g = expected_grants.pop_front();
            if (rsp_if.status !== g.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, g.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.start_page !== g.start_page) begin
               $display("%0t: start_page mismatch: expected %0h actual %0h",
                        $time, g.start_page, rsp_if.start_page);
               error_count++;
            end
            if (rsp_if.granted_pages !== g.granted_pages) begin
               $display("%0t: granted_pages mismatch: expected %0d actual %0d",
                        $time, g.granted_pages, rsp_if.granted_pages);
               error_count++;
            end
            case (g.status)
               ST_OK:       ok_count++;
               ST_DROPPED:  dropped_count++;
               ST_BAD_SIZE: bad_count++;
               default:     oom_count++;
            endcase
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("page_span_split_allocator_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.pages_wanted = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.addr         = '0;
      csr_if.wdata        = '0;
      error_count   = 0;
      idle_cycles   = 0;
      writes_done   = 0;
      drains_done   = 0;
      ok_count      = 0;
      dropped_count = 0;
      bad_count     = 0;
      oom_count     = 0;

      // Directed: bad sizes, exact fits, a split and its reuse, a full list
      plan_alloc(8'd0);
      plan_alloc(8'd255);
      plan_alloc(8'd128);
      plan_alloc(8'd127);
      plan_alloc(8'd1);
      plan_alloc(8'd126);
      plan_alloc(8'd64);
      plan_alloc(8'd63);
      for (int i = 0; i < LIST_DEPTH + 1; i++)
         plan_alloc(8'd100);
      plan_random(200);

      // Pool at the top of the page space, no limit
      plan_settle();
      plan_write(CSR_POOL_BASE, 32'hFFFF_FFFF, 1'b0);
      plan_write(CSR_POOL_LIMIT, 32'hFFFF_FFFF, 1'b0);
      plan_random(220);

      // Nearly exhausted pool: room for five more fresh blocks
      plan_settle();
      plan_write(CSR_POOL_BASE, $urandom, 1'b0);
      plan_write(CSR_POOL_LIMIT, 32'(5 * BIG_RUN), 1'b1);
      plan_random(220);

      // No pool at all: only the free lists can serve
      plan_settle();
      plan_write(CSR_POOL_BASE, 32'h0000_0000, 1'b0);
      plan_write(CSR_POOL_LIMIT, 32'h0000_0000, 1'b0);
      plan_random(150);

      // Unlimited pool at a random base, with a full drain midway
      plan_settle();
      plan_write(CSR_POOL_BASE, $urandom, 1'b0);
      plan_write(CSR_POOL_LIMIT, 32'hFFFF_FFFF, 1'b0);
      plan_random(120);
      plan_settle();
      plan_random(130);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for the plan to empty and every grant to come back
      @(posedge clock);
      while (request_plan.size() != 0 || req_busy || csr_busy
             || expected_grants.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d grants: %0d ok, %0d with remainder dropped, %0d bad size, %0d out of memory",
               ok_count + dropped_count + bad_count + oom_count, ok_count, dropped_count,
               bad_count, oom_count);
      $display("Pool registers written %0d times across five settings, %0d full drains",
               writes_done, drains_done);
      if (error_count == 0 && expected_grants.size() == 0) begin
         $display("page_span_split_allocator_test: done, clean");
      end else begin
         $display("page_span_split_allocator_test: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/pssa_pkg.sv
rtl/core/pssa_intf.sv
rtl/core/pssa_ram.sv
rtl/core/pssa_ctrl.sv
rtl/core/pssa_dpath.sv
rtl/core/page_span_split_allocator.sv
rtl/core/pssa_checker.sv
bench/page_span_split_allocator_test.sv
